/* hw/rtl/umsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB-MIDI SysEx command parser package
// Shared types, constants and register codes for the parser blocks.
// ----------------------------------------------------------------------------
package umsp_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int FADER_COUNT  = 8;
	localparam int HEAD_LEN     = 6;
	localparam int QUEUE_DEPTH  = 4;

	localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int HIDX_W = $clog2(HEAD_LEN);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] CIN_MASK     = 4'hF;
	localparam logic [3:0] CIN_SYSEX_LO = 4'h4;
	localparam logic [3:0] CIN_SYSEX_HI = 4'h7;
	localparam logic [3:0] CIN_BEND     = 4'hE;

	localparam logic [7:0] SYX_OPEN  = 8'hF0;
	localparam logic [7:0] SYX_CLOSE = 8'hF7;

	localparam logic [1:0] REPLY_NONE    = 2'd0;
	localparam logic [1:0] REPLY_QUERY   = 2'd1;
	localparam logic [1:0] REPLY_VERSION = 2'd2;

	localparam logic [2:0] CFG_MAKER_FIRST  = 3'd0;
	localparam logic [2:0] CFG_MAKER_SECOND = 3'd1;
	localparam logic [2:0] CFG_MAKER_THIRD  = 3'd2;
	localparam logic [2:0] CFG_DEVICE       = 3'd3;
	localparam logic [2:0] CFG_QUERY        = 3'd4;
	localparam logic [2:0] CFG_VERSION      = 3'd5;

	typedef struct packed {
		logic [7:0] packet_header;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] reply_event;
		logic       message_closed;
		logic       fader_written;
		logic [2:0] fader_channel;
		logic [7:0] fader_level;
	} out_item_t;

	typedef struct packed {
		logic       sysex;
		logic       open;
		logic       close;
		logic       nz2;
		logic       nz3;
		logic       bend;
		logic [2:0] chan;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} cls_t;

endpackage

/* hw/rtl/umsp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB-MIDI parser front end
// Decodes the code index number and the byte markers of each event packet.
// ----------------------------------------------------------------------------
module umsp_front (
	input  umsp_pkg::in_item_t pkt,
	output umsp_pkg::cls_t     cls
);
	import umsp_pkg::*;

	logic [3:0] cin;
	logic [3:0] ch;

	always_comb begin
		cin       = pkt.packet_header[3:0] & CIN_MASK;
		ch        = pkt.first_byte[3:0];
		cls.sysex = (cin >= CIN_SYSEX_LO) && (cin <= CIN_SYSEX_HI);
		cls.open  = (pkt.first_byte == SYX_OPEN);
		cls.close = (pkt.first_byte == SYX_CLOSE) || (pkt.second_byte == SYX_CLOSE)
			|| (pkt.third_byte == SYX_CLOSE);
		cls.nz2   = (pkt.second_byte != 8'd0);
		cls.nz3   = (pkt.third_byte != 8'd0);
		cls.bend  = (cin == CIN_BEND) && ({1'b0, ch} < 5'(FADER_COUNT));
		cls.chan  = ch[2:0];
		cls.b1    = pkt.first_byte;
		cls.b2    = pkt.second_byte;
		cls.b3    = pkt.third_byte;
	end

endmodule

/* hw/rtl/umsp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB-MIDI parser decode queue
// Short first-in first-out store between the decoder and the executor.
// ----------------------------------------------------------------------------
module umsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  umsp_pkg::cls_t push_data,
	output logic           full,
	input  logic           pop,
	output umsp_pkg::cls_t pop_data,
	output logic           not_empty
);
	import umsp_pkg::*;

	cls_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/umsp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB-MIDI parser executor
// Holds the configuration and SysEx state, reassembles messages and
// registers one result item per decoded packet.
// ----------------------------------------------------------------------------
module umsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	input  logic                q_valid,
	input  umsp_pkg::cls_t      q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output umsp_pkg::out_item_t out_item
);
	import umsp_pkg::*;

	logic [6:0]        maker_first_q;
	logic [6:0]        maker_second_q;
	logic [6:0]        maker_third_q;
	logic [6:0]        device_q;
	logic [6:0]        query_q;
	logic [6:0]        version_q;

	logic [7:0]        head_q [HEAD_LEN];
	logic [CNT_W-1:0]  cnt_q;
	logic              inside_q;

	logic [7:0]        head_n [HEAD_LEN];
	logic [CNT_W-1:0]  cnt_n;
	logic              inside_n;
	out_item_t         res;
	logic              out_valid_q;
	out_item_t         out_q;

	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		logic             active;
		logic [2:0]       en;
		logic [2:0][7:0]  pb;
		logic [CNT_W-1:0] c;
		logic             match;
		head_n   = head_q;
		cnt_n    = cnt_q;
		inside_n = inside_q;
		res      = '0;
		active   = q_data.open || inside_q;
		en[0]    = active;
		en[1]    = q_data.open || (inside_q && q_data.nz2);
		en[2]    = active && q_data.nz3;
		pb[0]    = q_data.b1;
		pb[1]    = q_data.b2;
		pb[2]    = q_data.b3;
		c        = q_data.open ? '0 : cnt_q;
		for (int k = 0; k < 3; k++) begin
			if (en[k] && (c < CNT_W'(BUFFER_DEPTH))) begin
				if (c < CNT_W'(HEAD_LEN)) begin
					head_n[c[HIDX_W-1:0]] = pb[k];
				end
				c = c + CNT_W'(1);
			end
		end
		match = (c >= CNT_W'(HEAD_LEN))
			&& (head_n[1] == {1'b0, maker_first_q})
			&& (head_n[2] == {1'b0, maker_second_q})
			&& (head_n[3] == {1'b0, maker_third_q})
			&& (head_n[4] == {1'b0, device_q});
		if (q_data.sysex) begin
			if (q_data.close) begin
				inside_n           = 1'b0;
				cnt_n              = '0;
				res.message_closed = 1'b1;
				priority if (match && (head_n[5] == {1'b0, query_q})) begin
					res.reply_event = REPLY_QUERY;
				end else if (match && (head_n[5] == {1'b0, version_q})) begin
					res.reply_event = REPLY_VERSION;
				end else begin
					res.reply_event = REPLY_NONE;
				end
			end else begin
				inside_n = active;
				cnt_n    = c;
			end
		end else begin
			head_n = head_q;
			if (q_data.bend) begin
				res.fader_written = 1'b1;
				res.fader_channel = q_data.chan;
				res.fader_level   = q_data.b3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maker_first_q  <= 7'd0;
			maker_second_q <= 7'd0;
			maker_third_q  <= 7'd102;
			device_q       <= 7'd20;
			query_q        <= 7'd0;
			version_q      <= 7'd19;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAKER_FIRST:  maker_first_q  <= cfg_data;
				CFG_MAKER_SECOND: maker_second_q <= cfg_data;
				CFG_MAKER_THIRD:  maker_third_q  <= cfg_data;
				CFG_DEVICE:       device_q       <= cfg_data;
				CFG_QUERY:        query_q        <= cfg_data;
				CFG_VERSION:      version_q      <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HEAD_LEN; i++) begin
				head_q[i] <= 8'd0;
			end
			cnt_q       <= '0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				head_q      <= head_n;
				cnt_q       <= cnt_n;
				inside_q    <= inside_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res;
		end
	end

endmodule

/* hw/rtl/usb_midi_sysex_command_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB-MIDI SysEx command parser
// Accepted packets are queued; each result is then registered by the executor.
// Throughput: one packet per cycle while the output is not stalled.
// The four-entry decode queue absorbs output stalls before input stalls.
// Reset clears the configuration to defaults and empties all SysEx state.
// ----------------------------------------------------------------------------
module usb_midi_sysex_command_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  umsp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output umsp_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [6:0]          cfg_data
);
	import umsp_pkg::*;

	cls_t front_cls;
	cls_t q_data;
	logic q_full;
	logic q_valid;
	logic q_pop;

	assign in_stall  = q_full;
	assign cfg_ready = 1'b1;

	umsp_front u_front (
		.pkt (in_item),
		.cls (front_cls)
	);

	umsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_data (front_cls),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.not_empty (q_valid)
	);

	umsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

/* hw/rtl/umsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB-MIDI parser port checker
// Checks the result channel of the parser as seen on its ports.
// ----------------------------------------------------------------------------
module umsp_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_stall,
	input  umsp_pkg::out_item_t out_item
);
	import umsp_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result item withdrawn while stalled.");

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("Result item changed while stalled.");

	a_reply_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.reply_event != REPLY_NONE) |-> out_item.message_closed)
		else $error("Reply raised without a closed message.");

	a_fader_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.fader_written |->
			!out_item.message_closed && (out_item.reply_event == REPLY_NONE))
		else $error("Fader update mixed with a SysEx result.");

	a_fader_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.fader_written |->
			(out_item.fader_channel == 3'd0) && (out_item.fader_level == 8'd0))
		else $error("Fader fields set without a fader update.");

endmodule

bind usb_midi_sysex_command_parser_top umsp_checker u_umsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

/* tb/sv/tb_usb_midi_sysex_command_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB-MIDI SysEx command parser testbench
// Sends USB-MIDI event packets through the parser under several register
// settings, random idling on both channels, and compares every result item
// with a typed expected item or a packet decoder kept in step in the testbench.
// ----------------------------------------------------------------------------
module tb_usb_midi_sysex_command_parser_top;
	import umsp_pkg::*;

	localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
	localparam logic [3:0] CIN_CONTROL  = 4'hB;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam int         PHASE_ITEMS  = 100;
	localparam int         PHASES       = 6;

	typedef struct {
		in_item_t  pkt;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	logic [6:0]  reg_shadow [6];
	logic [6:0]  setting [6];
	logic [7:0]  head_bytes [HEAD_LEN];
	int unsigned fill_level;
	bit          msg_open;
	logic [7:0]  fader_pos [FADER_COUNT];

	out_item_t awaited_results [$];
	stim_row_t directed_rows [$];
	out_item_t want_now;
	int        mismatches = 0;
	int        useful_items = 0;
	int        total_items = 0;
	int        calm_in_left = 0;
	int        n_query = 0;
	int        n_version = 0;
	int        n_closed = 0;
	int        n_fader = 0;

	usb_midi_sysex_command_parser_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("usb_midi_sysex_command_parser_top verification failed");
		$finish;
	end

	function automatic in_item_t make_packet(logic [7:0] h, logic [7:0] a, logic [7:0] b,
			logic [7:0] c);
		in_item_t p;
		p.packet_header = h;
		p.first_byte = a;
		p.second_byte = b;
		p.third_byte = c;
		return p;
	endfunction

	function automatic out_item_t make_result(logic [1:0] reply, logic closed, logic written,
			logic [2:0] chan, logic [7:0] level);
		out_item_t r;
		r.reply_event = reply;
		r.message_closed = closed;
		r.fader_written = written;
		r.fader_channel = chan;
		r.fader_level = level;
		return r;
	endfunction

	function automatic void append_byte(logic [7:0] b);
		if (fill_level < BUFFER_DEPTH) begin
			if (fill_level < HEAD_LEN)
				head_bytes[3'(fill_level)] = b;
			fill_level++;
		end
	endfunction

	function automatic out_item_t decode_packet(in_item_t p);
		logic [3:0] cin;
		out_item_t r;
		cin = p.packet_header[3:0];
		r = '0;
		if (cin >= CIN_SYSEX_LO && cin <= CIN_SYSEX_HI) begin
			if (p.first_byte == SYX_OPEN) begin
				msg_open = 1'b1;
				fill_level = 0;
				append_byte(p.first_byte);
				append_byte(p.second_byte);
				if (p.third_byte != 8'h00)
					append_byte(p.third_byte);
			end else if (msg_open) begin
				append_byte(p.first_byte);
				if (p.second_byte != 8'h00)
					append_byte(p.second_byte);
				if (p.third_byte != 8'h00)
					append_byte(p.third_byte);
			end
			if (p.first_byte == SYX_CLOSE || p.second_byte == SYX_CLOSE ||
					p.third_byte == SYX_CLOSE) begin
				msg_open = 1'b0;
				r.message_closed = 1'b1;
				if (fill_level >= HEAD_LEN &&
						head_bytes[1] == {1'b0, reg_shadow[CFG_MAKER_FIRST]} &&
						head_bytes[2] == {1'b0, reg_shadow[CFG_MAKER_SECOND]} &&
						head_bytes[3] == {1'b0, reg_shadow[CFG_MAKER_THIRD]} &&
						head_bytes[4] == {1'b0, reg_shadow[CFG_DEVICE]}) begin
					if (head_bytes[5] == {1'b0, reg_shadow[CFG_QUERY]})
						r.reply_event = REPLY_QUERY;
					else if (head_bytes[5] == {1'b0, reg_shadow[CFG_VERSION]})
						r.reply_event = REPLY_VERSION;
				end
				fill_level = 0;
			end
		end else if (cin == CIN_BEND) begin
			if (p.first_byte[3:0] < FADER_COUNT) begin
				fader_pos[p.first_byte[2:0]] = p.third_byte;
				r.fader_written = 1'b1;
				r.fader_channel = p.first_byte[2:0];
				r.fader_level = p.third_byte;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] data7();
		if ($urandom_range(0, 3) == 0)
			return 8'h00;
		return {1'b0, 7'($urandom)};
	endfunction

	function automatic logic [7:0] corrupt(logic [7:0] b);
		if ($urandom_range(0, 15) == 0)
			return 8'($urandom);
		return b;
	endfunction

	function automatic logic [7:0] sysex_header();
		return {4'($urandom), 4'($urandom_range(CIN_SYSEX_LO, CIN_SYSEX_HI))};
	endfunction

	task automatic add_row(in_item_t p, bit typed, out_item_t want);
		stim_row_t row;
		row.pkt = p;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic send_packet(in_item_t p, bit typed, out_item_t want);
		int gap;
		out_item_t pred;
		logic [3:0] cin;
		if (calm_in_left > 0) begin
			calm_in_left--;
			gap = 0;
		end else if ($urandom_range(0, 19) == 0) begin
			calm_in_left = $urandom_range(10, 40);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 14);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= p;
		do @(posedge clk); while (in_stall);
		pred = decode_packet(p);
		cin = p.packet_header[3:0];
		total_items++;
		if ((cin >= CIN_SYSEX_LO && cin <= CIN_SYSEX_HI) || cin == CIN_BEND)
			useful_items++;
		n_query += (pred.reply_event == REPLY_QUERY);
		n_version += (pred.reply_event == REPLY_VERSION);
		n_closed += pred.message_closed;
		n_fader += pred.fader_written;
		awaited_results.push_back(typed ? want : pred);
	endtask

	task automatic write_register(logic [2:0] idx, logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < 3'd6)
			reg_shadow[idx] = val;
	endtask

	task automatic program_all();
		for (int i = 0; i < 6; i++)
			write_register(3'(i), setting[i]);
		write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 7'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_sysex_message();
		logic [7:0] body [4];
		logic [3:0] cable;
		int extra;
		body[0] = corrupt({1'b0, reg_shadow[CFG_MAKER_SECOND]});
		body[1] = corrupt({1'b0, reg_shadow[CFG_MAKER_THIRD]});
		body[2] = corrupt({1'b0, reg_shadow[CFG_DEVICE]});
		case ($urandom_range(0, 2))
			0: body[3] = {1'b0, reg_shadow[CFG_QUERY]};
			1: body[3] = {1'b0, reg_shadow[CFG_VERSION]};
			default: body[3] = data7();
		endcase
		body[3] = corrupt(body[3]);
		send_packet(make_packet(sysex_header(), SYX_OPEN,
			corrupt({1'b0, reg_shadow[CFG_MAKER_FIRST]}), 8'h00), 1'b0, '0);
		if (body[1] != 8'h00 && body[2] != 8'h00 && $urandom_range(0, 1)) begin
			send_packet(make_packet(sysex_header(), body[0], body[1], body[2]), 1'b0, '0);
			send_packet(make_packet(sysex_header(), body[3], 8'h00, 8'h00), 1'b0, '0);
		end else begin
			for (int k = 0; k < 4; k++)
				send_packet(make_packet(sysex_header(), body[k], 8'h00, 8'h00), 1'b0, '0);
		end
		extra = $urandom_range(0, 12);
		for (int k = 0; k < extra; k++)
			send_packet(make_packet(sysex_header(), data7(), data7(), data7()), 1'b0, '0);
		if ($urandom_range(0, 9) == 0)
			return;
		cable = 4'($urandom);
		case ($urandom_range(0, 2))
			0: send_packet(make_packet({cable, 4'h5}, SYX_CLOSE, 8'h00, 8'h00), 1'b0, '0);
			1: send_packet(make_packet({cable, 4'h6}, data7(), SYX_CLOSE, 8'h00), 1'b0, '0);
			default: send_packet(make_packet({cable, 4'h7}, data7(), data7(), SYX_CLOSE),
				1'b0, '0);
		endcase
	endtask

	task automatic send_random_phase();
		int goal;
		goal = useful_items + PHASE_ITEMS;
		while (useful_items < goal) begin
			case ($urandom_range(0, 9))
				6, 7: send_packet(make_packet({4'($urandom), CIN_BEND}, 8'($urandom),
					8'($urandom), 8'($urandom)), 1'b0, '0);
				8, 9: send_packet(in_item_t'($urandom), 1'b0, '0);
				default: send_sysex_message();
			endcase
		end
	endtask

	initial begin
		int hold;
		int calm_left;
		calm_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (calm_left > 0) begin
				calm_left--;
				hold = 0;
			end else if ($urandom_range(0, 19) == 0) begin
				calm_left = $urandom_range(10, 40);
				hold = 0;
			end else begin
				hold = $urandom_range(0, 14);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic report_mismatch(string why, out_item_t want, out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%s: expected reply %0d closed %0b fader %0b ch %0d lvl %0h,",
				" got reply %0d closed %0b fader %0b ch %0d lvl %0h"},
				why, want.reply_event, want.message_closed, want.fader_written,
				want.fader_channel, want.fader_level, got.reply_event, got.message_closed,
				got.fader_written, got.fader_channel, got.fader_level);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("Result item with nothing awaited", '0, out_item);
			end else begin
				want_now = awaited_results.pop_front();
				if (out_item.reply_event !== want_now.reply_event ||
						out_item.message_closed !== want_now.message_closed ||
						out_item.fader_written !== want_now.fader_written ||
						out_item.fader_channel !== want_now.fader_channel ||
						out_item.fader_level !== want_now.fader_level)
					report_mismatch("Result item mismatch", want_now, out_item);
			end
		end
	end

	initial begin
		reg_shadow = '{7'd0, 7'd0, 7'd102, 7'd20, 7'd0, 7'd19};
		setting = reg_shadow;
		head_bytes = '{default: 8'h00};
		fader_pos = '{default: 8'h00};
		fill_level = 0;
		msg_open = 1'b0;

		add_row(make_packet(8'h0E, 8'hE0, 8'h00, 8'hFF), 1'b1,
			make_result(REPLY_NONE, 1'b0, 1'b1, 3'd0, 8'hFF));
		add_row(make_packet(8'h0E, 8'hEF, 8'h7F, 8'h80), 1'b1, '0);
		add_row(make_packet(8'hFE, 8'hE7, 8'h00, 8'h00), 1'b1,
			make_result(REPLY_NONE, 1'b0, 1'b1, 3'd7, 8'h00));
		add_row(make_packet({4'h0, CIN_NOTE_ON}, 8'h90, 8'h3C, 8'h7F), 1'b1, '0);
		add_row(make_packet({4'h0, CIN_CONTROL}, 8'hB0, 8'h07, 8'h64), 1'b1, '0);
		add_row(make_packet(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1, '0);
		add_row(make_packet(8'h00, 8'h00, 8'h00, 8'h00), 1'b1, '0);
		add_row(make_packet(8'h05, SYX_CLOSE, 8'h00, 8'h00), 1'b1,
			make_result(REPLY_NONE, 1'b1, 1'b0, 3'd0, 8'h00));
		add_row(make_packet(8'h04, 8'h01, 8'h02, 8'h03), 1'b1, '0);
		add_row(make_packet(8'h04, SYX_OPEN, 8'h00, 8'h00), 1'b1, '0);
		add_row(make_packet(8'h04, 8'h00, 8'h66, 8'h14), 1'b1, '0);
		add_row(make_packet(8'h07, 8'h00, SYX_CLOSE, 8'h00), 1'b1,
			make_result(REPLY_QUERY, 1'b1, 1'b0, 3'd0, 8'h00));
		add_row(make_packet(8'h04, SYX_OPEN, 8'h00, 8'h00), 1'b1, '0);
		add_row(make_packet(8'h04, 8'h00, 8'h66, 8'h14), 1'b1, '0);
		add_row(make_packet(8'h06, 8'h13, SYX_CLOSE, 8'h00), 1'b1,
			make_result(REPLY_VERSION, 1'b1, 1'b0, 3'd0, 8'h00));
		add_row(make_packet(8'h04, SYX_OPEN, 8'h00, 8'h00), 1'b1, '0);
		add_row(make_packet(8'h04, 8'h00, 8'h66, 8'h14), 1'b1, '0);
		add_row(make_packet(8'h06, 8'h80, SYX_CLOSE, 8'h00), 1'b1,
			make_result(REPLY_NONE, 1'b1, 1'b0, 3'd0, 8'h00));
		add_row(make_packet(8'h04, SYX_OPEN, 8'h00, 8'h00), 1'b1, '0);
		add_row(make_packet(8'h06, 8'h66, SYX_CLOSE, 8'h00), 1'b1,
			make_result(REPLY_NONE, 1'b1, 1'b0, 3'd0, 8'h00));
		add_row(make_packet(8'h14, SYX_OPEN, 8'h7F, 8'h7F), 1'b0, '0);
		add_row(make_packet(8'h14, SYX_OPEN, 8'h00, 8'h66), 1'b0, '0);
		add_row(make_packet(8'h17, 8'h7F, 8'h7F, SYX_CLOSE), 1'b0, '0);
		add_row(make_packet(8'h2E, 8'hE3, 8'h12, 8'h55), 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_idle();
				for (int i = 0; i < 6; i++) begin
					case (ph)
						1: setting[i] = 7'd0;
						2: setting[i] = 7'd127;
						default: setting[i] = 7'($urandom);
					endcase
				end
				if (ph == 4)
					setting[CFG_VERSION] = setting[CFG_QUERY];
			end
			program_all();
			if (ph == 0)
				foreach (directed_rows[i])
					send_packet(directed_rows[i].pkt, directed_rows[i].typed,
						directed_rows[i].want);
			send_random_phase();
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
		repeat (10) @(posedge clk);

		$display("Run covered %0d packets under %0d register settings, directed rows included.",
			total_items, PHASES);
		$display({"Seen: %0d query replies, %0d version replies, %0d closed messages,",
			" %0d fader writes, %0d mismatches."},
			n_query, n_version, n_closed, n_fader, mismatches);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("usb_midi_sysex_command_parser_top verification clean");
		else
			$display("usb_midi_sysex_command_parser_top verification failed");
		$finish;
	end

endmodule
